[rtl/tct_pkg.sv]
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and codes for the touch contact tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam logic [1:0] MODE_FRAME = 2'd0;
    localparam logic [1:0] MODE_TOKEN = 2'd1;
    localparam logic [1:0] MODE_ALIVE = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [1:0] KIND_IDLE = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_ON   = 2'd2;
    localparam logic [1:0] KIND_SET  = 2'd3;

    localparam logic [31:0] FRAME_RESTART = 32'd1;
    localparam int          ID_SPLIT      = 16;

    typedef struct packed {
        logic        valid;
        logic        fresh;
        logic        alive;
        logic [31:0] session;
        logic [15:0] user;
        logic [15:0] type_id;
        logic [31:0] group;
        logic [31:0] xpos;
        logic [31:0] ypos;
        logic [31:0] angle;
    } entry_t;

    typedef struct packed {
        logic kill;
        logic shift;
        logic load;
        logic insert;
        logic mark;
        logic clr_alive;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] session;
        logic [15:0] user;
        logic [15:0] type_id;
        logic [31:0] group;
        logic [31:0] xpos;
        logic [31:0] ypos;
        logic [31:0] angle;
    } event_t;

endpackage

[rtl/tct_cell.sv]
// ----------------------------------------------------------------------------
// tct_cell
// One contact cell of the chain: holds one entry, matches a session id,
// takes a token write or the entry of its upper neighbor.
// ----------------------------------------------------------------------------
module tct_cell
    import tct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctl_t   ctl,
    input  entry_t      nxt_in,
    input  entry_t      tok,
    input  logic [31:0] sid,
    output entry_t      ent,
    output logic        hit
);

    logic ctl_valid_reg, ctl_valid_next;
    logic fresh_reg, fresh_next;
    logic alive_reg, alive_next;
    entry_t data_reg, data_next;

    assign hit = ctl_valid_reg && (data_reg.session == sid);

    always_comb
    begin
        ctl_valid_next = ctl_valid_reg;
        fresh_next     = fresh_reg;
        alive_next     = alive_reg;
        data_next      = data_reg;
        priority if (ctl.kill)
        begin
            ctl_valid_next = 1'b0;
            fresh_next     = 1'b0;
            alive_next     = 1'b0;
        end
        else if (ctl.shift)
        begin
            ctl_valid_next = nxt_in.valid;
            fresh_next     = nxt_in.fresh;
            alive_next     = nxt_in.alive;
            data_next      = nxt_in;
        end
        else if (ctl.load)
        begin
            data_next      = tok;
            ctl_valid_next = 1'b1;
            if (ctl.insert)
            begin
                fresh_next = 1'b1;
                alive_next = 1'b0;
            end
        end
        else if (ctl.mark)
        begin
            alive_next = 1'b1;
        end
        else if (ctl.clr_alive)
        begin
            alive_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_valid_reg <= 1'b0;
            fresh_reg     <= 1'b0;
            alive_reg     <= 1'b0;
        end
        else
        begin
            ctl_valid_reg <= ctl_valid_next;
            fresh_reg     <= fresh_next;
            alive_reg     <= alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        ent       = data_reg;
        ent.valid = ctl_valid_reg;
        ent.fresh = fresh_reg;
        ent.alive = alive_reg;
    end

endmodule

[rtl/touch_contact_tracker.sv]
// ----------------------------------------------------------------------------
// touch_contact_tracker
// Contact table kept as a chain of cells in insertion order.
// ----------------------------------------------------------------------------
// Frame, token and alive entries that end no list leave busy low.
// An alive list end runs an off pass, a compaction pass and an on/set pass,
// then a flush; the off and on/set passes each rotate the whole cell chain.
// Events leave one per cycle at most, each on a one-cycle out_valid strobe.
// An empty list end on an empty table gives its idle event in the following cycle.
// Reset clears the table, the frame counters, the state and the pending and output valid flags.
module touch_contact_tracker
    import tct_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [31:0]        event_time,
    input  logic [31:0]        frame_id,
    input  logic [31:0]        session_id,
    input  logic [31:0]        type_user_id,
    input  logic [31:0]        group_id,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] angle,
    input  logic               list_end,
    input  logic               list_empty,
    output logic               out_valid,
    output logic [1:0]         kind,
    output logic [31:0]        out_time,
    output logic [31:0]        out_session,
    output logic [15:0]        out_user,
    output logic [15:0]        out_type,
    output logic [31:0]        out_group,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_angle,
    output logic               last
);

    localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [SW-1:0] STEP_LAST = SW'(MAX_ENTRIES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_OFF   = 3'd1;
    localparam logic [2:0] ST_COMP  = 3'd2;
    localparam logic [2:0] ST_ON    = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic          empty_reg, empty_next;
    logic [31:0]   time_reg, time_next;
    logic [31:0]   last_frame_reg, last_frame_next;
    logic [31:0]   missing_reg, missing_next;
    logic          ignore_reg, ignore_next;
    logic          pend_valid_reg, pend_valid_next;
    event_t        pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    logic          last_reg, last_next;
    logic [31:0]   otime_reg, otime_next;
    event_t        out_reg, out_next;

    entry_t        ent [MAX_ENTRIES];
    entry_t        nxt [MAX_ENTRIES];
    cell_ctl_t     ctl [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] hit;
    logic [MAX_ENTRIES-1:0] vld;
    logic [MAX_ENTRIES-1:0] hole_pref;
    logic [MAX_ENTRIES-1:0] first_free;
    entry_t        tok;
    entry_t        tail_in;
    entry_t        head;
    logic          acc, tok_en, mark_en, frame_en, end_en, any_hit, any_valid;
    logic          ev_valid;
    event_t        ev;
    logic [32:0]   gap, sum;

    assign acc      = start && !busy;
    assign frame_en = acc && (mode == MODE_FRAME);
    assign tok_en   = acc && (mode == MODE_TOKEN) && !ignore_reg;
    assign mark_en  = acc && (mode == MODE_ALIVE) && !ignore_reg && !list_empty;
    assign end_en   = acc && (mode == MODE_ALIVE) && !ignore_reg && list_end;
    assign any_hit  = |hit;
    assign any_valid = |vld;
    assign head     = ent[0];

    always_comb
    begin
        tok         = '0;
        tok.valid   = 1'b1;
        tok.session = session_id;
        tok.user    = type_user_id[31:ID_SPLIT];
        tok.type_id = type_user_id[ID_SPLIT-1:0];
        tok.group   = group_id;
        tok.xpos    = pos_x;
        tok.ypos    = pos_y;
        tok.angle   = angle;
    end

    // Head wraps around to the tail (compaction feeds empty cells); off pass drops, on pass retires "new".
    always_comb
    begin
        tail_in = head;
        unique case (state_reg)
            ST_OFF:
            begin
                if (empty_reg || !head.alive)
                begin
                    tail_in.valid = 1'b0;
                    tail_in.fresh = 1'b0;
                end
            end
            ST_ON:
            begin
                tail_in.fresh = 1'b0;
                tail_in.alive = 1'b0;
            end
            ST_COMP:  tail_in = '0;
            default:  tail_in = head;
        endcase
    end

    always_comb
    begin
        logic hole;
        hole = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            vld[i] = ent[i].valid;
            hole = hole | !ent[i].valid;
            hole_pref[i] = hole;
            if (i == 0)
                first_free[i] = !ent[i].valid;
            else
                first_free[i] = !ent[i].valid && ent[i-1].valid;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            ctl[i].kill      = frame_en && (frame_id == FRAME_RESTART);
            ctl[i].shift     = (state_reg == ST_OFF) || (state_reg == ST_ON) ||
                               ((state_reg == ST_COMP) && hole_pref[i]);
            ctl[i].load      = tok_en && (hit[i] || (!any_hit && first_free[i]));
            ctl[i].insert    = !any_hit;
            ctl[i].mark      = mark_en && hit[i];
            ctl[i].clr_alive = frame_en;
            if (i < MAX_ENTRIES - 1)
                nxt[i] = ent[i+1];
            else
                nxt[i] = tail_in;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            tct_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl[g]),
                .nxt_in (nxt[g]),
                .tok    (tok),
                .sid    (session_id),
                .ent    (ent[g]),
                .hit    (hit[g])
            );
        end
    endgenerate

    always_comb
    begin
        ev         = '0;
        ev.session = head.session;
        ev.user    = head.user;
        ev.type_id = head.type_id;
        ev.group   = head.group;
        ev_valid   = 1'b0;
        if (state_reg == ST_OFF)
        begin
            ev_valid = head.valid && (empty_reg || !head.alive);
            ev.kind  = KIND_OFF;
        end
        else if (state_reg == ST_ON)
        begin
            ev_valid = head.valid;
            ev.kind  = head.fresh ? KIND_ON : KIND_SET;
            ev.xpos  = head.xpos;
            ev.ypos  = head.ypos;
            ev.angle = head.angle;
        end
    end

    assign gap = {1'b0, frame_id} - {1'b0, last_frame_reg} - 33'd1;
    assign sum = {1'b0, missing_reg} + gap;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        empty_next      = empty_reg;
        time_next       = time_reg;
        last_frame_next = last_frame_reg;
        missing_next    = missing_reg;
        ignore_next     = ignore_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = 1'b0;
        last_next       = last_reg;
        otime_next      = otime_reg;
        out_next        = out_reg;

        if (frame_en)
        begin
            ignore_next = 1'b0;
            priority if (frame_id == FRAME_RESTART)
            begin
                missing_next    = '0;
                last_frame_next = frame_id;
            end
            else if ((frame_id < last_frame_reg) && (missing_reg != '0))
            begin
                ignore_next  = 1'b1;
                missing_next = missing_reg - 32'd1;
            end
            else
            begin
                if ((last_frame_reg != FRAME_RESTART) &&
                    ({1'b0, frame_id} > ({1'b0, last_frame_reg} + 33'd1)))
                    missing_next = sum[32] ? '1 : sum[31:0];
                last_frame_next = frame_id;
            end
        end

        if (end_en)
        begin
            time_next  = event_time;
            empty_next = list_empty;
            if (list_empty && !any_valid)
            begin
                out_valid_next = 1'b1;
                last_next      = 1'b1;
                otime_next     = event_time;
                out_next       = '0;
                out_next.kind  = KIND_IDLE;
            end
            else
            begin
                state_next = ST_OFF;
                step_next  = '0;
            end
        end

        // Hold each event back one slot so the final one can carry last.
        if (ev_valid)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                last_next      = 1'b0;
                otime_next     = time_reg;
                out_next       = pend_reg;
            end
            pend_valid_next = 1'b1;
            pend_next       = ev;
        end

        unique case (state_reg)
            ST_OFF, ST_COMP, ST_ON:
            begin
                step_next = step_reg + SW'(1);
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    if (state_reg == ST_OFF)
                        state_next = ST_COMP;
                    else if (state_reg == ST_COMP)
                        state_next = ST_ON;
                    else
                        state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    otime_next     = time_reg;
                    out_next       = pend_reg;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            last_frame_reg <= '0;
            missing_reg    <= '0;
            ignore_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            last_frame_reg <= last_frame_next;
            missing_reg    <= missing_next;
            ignore_reg     <= ignore_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        empty_reg <= empty_next;
        time_reg  <= time_next;
        pend_reg  <= pend_next;
        last_reg  <= last_next;
        otime_reg <= otime_next;
        out_reg   <= out_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign out_time    = otime_reg;
    assign out_session = out_reg.session;
    assign out_user    = out_reg.user;
    assign out_type    = out_reg.type_id;
    assign out_group   = out_reg.group;
    assign out_x       = out_reg.xpos;
    assign out_y       = out_reg.ypos;
    assign out_angle   = out_reg.angle;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending event left behind in idle");

    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (((vld + 1'b1) & vld) == '0))
        else $error("contact chain has a hole while idle");

    a_mid_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (state_reg != ST_IDLE))
        else $error("non-final event outside a list walk");
`endif

endmodule
